// ----- rtl/idpc_pkg.sv -----
package idpc_pkg;

  typedef enum logic [1:0] {
    LVL_OFF    = 2'd0,
    LVL_DIM    = 2'd1,
    LVL_BRIGHT = 2'd2
  } level_e;

  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned ByteWidth    = 8;
  localparam int unsigned TicksWidth   = 10;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned StepWidth    = 3;
  localparam int unsigned QueueDepth   = 2;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] REG_DIM_TIMEOUT      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_OFF_TIMEOUT      = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_BRIGHT_VCOMH     = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_BRIGHT_PRECHARGE = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_BRIGHT_CONTRAST  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_DIM_VCOMH        = 3'd5;
  localparam logic [CfgIdxWidth-1:0] REG_DIM_PRECHARGE    = 3'd6;
  localparam logic [CfgIdxWidth-1:0] REG_DIM_CONTRAST     = 3'd7;

  // panel commands
  localparam logic [ByteWidth-1:0] CMD_DISPLAY_OFF   = 8'hAE;
  localparam logic [ByteWidth-1:0] CMD_DISPLAY_ON    = 8'hAF;
  localparam logic [ByteWidth-1:0] CMD_SET_VCOMH     = 8'hDB;
  localparam logic [ByteWidth-1:0] CMD_SET_PRECHARGE = 8'hD9;
  localparam logic [ByteWidth-1:0] CMD_SET_CONTRAST  = 8'h81;

  // steps of a power-up run
  localparam logic [StepWidth-1:0] STEP_ON        = 3'd0;
  localparam logic [StepWidth-1:0] STEP_VCOMH_CMD = 3'd1;
  localparam logic [StepWidth-1:0] STEP_VCOMH_VAL = 3'd2;
  localparam logic [StepWidth-1:0] STEP_PRE_CMD   = 3'd3;
  localparam logic [StepWidth-1:0] STEP_PRE_VAL   = 3'd4;
  localparam logic [StepWidth-1:0] STEP_CON_CMD   = 3'd5;
  localparam logic [StepWidth-1:0] STEP_CON_VAL   = 3'd6;

  localparam logic [TimeoutWidth-1:0] DIM_TIMEOUT_RST      = 16'd3000;
  localparam logic [TimeoutWidth-1:0] OFF_TIMEOUT_RST      = 16'd7000;
  localparam logic [ByteWidth-1:0]    BRIGHT_VCOMH_RST     = 8'h3C;
  localparam logic [ByteWidth-1:0]    BRIGHT_PRECHARGE_RST = 8'hF1;
  localparam logic [ByteWidth-1:0]    BRIGHT_CONTRAST_RST  = 8'h0F;
  localparam logic [ByteWidth-1:0]    DIM_VCOMH_RST        = 8'h00;
  localparam logic [ByteWidth-1:0]    DIM_PRECHARGE_RST    = 8'h01;
  localparam logic [ByteWidth-1:0]    DIM_CONTRAST_RST     = 8'h01;

  typedef struct packed {
    logic [TimeoutWidth-1:0] dim_timeout;
    logic [TimeoutWidth-1:0] off_timeout;
    logic [ByteWidth-1:0]    bright_vcomh;
    logic [ByteWidth-1:0]    bright_precharge;
    logic [ByteWidth-1:0]    bright_contrast;
    logic [ByteWidth-1:0]    dim_vcomh;
    logic [ByteWidth-1:0]    dim_precharge;
    logic [ByteWidth-1:0]    dim_contrast;
  } cfg_t;

  typedef struct packed {
    logic   push;
    level_e level;
  } push_t;

  typedef struct packed {
    logic   empty;
    logic   full;
    level_e level;
  } q_stat_t;

  function automatic logic [ByteWidth-1:0] cmd_byte(level_e lvl, logic [StepWidth-1:0] step,
                                                   cfg_t cfg);
    logic [ByteWidth-1:0] vcomh;
    logic [ByteWidth-1:0] pre;
    logic [ByteWidth-1:0] con;
    logic [ByteWidth-1:0] res;
    vcomh = (lvl == LVL_DIM) ? cfg.dim_vcomh     : cfg.bright_vcomh;
    pre   = (lvl == LVL_DIM) ? cfg.dim_precharge : cfg.bright_precharge;
    con   = (lvl == LVL_DIM) ? cfg.dim_contrast  : cfg.bright_contrast;
    if (lvl == LVL_OFF) begin
      res = CMD_DISPLAY_OFF;
    end else begin
      unique case (step)
        STEP_ON:        res = CMD_DISPLAY_ON;
        STEP_VCOMH_CMD: res = CMD_SET_VCOMH;
        STEP_VCOMH_VAL: res = vcomh;
        STEP_PRE_CMD:   res = CMD_SET_PRECHARGE;
        STEP_PRE_VAL:   res = pre;
        STEP_CON_CMD:   res = CMD_SET_CONTRAST;
        STEP_CON_VAL:   res = con;
        default:        res = CMD_DISPLAY_ON;
      endcase
    end
    return res;
  endfunction

endpackage

// ----- rtl/idpc_scan_if.sv -----
interface idpc_scan_if;
  logic                               valid;
  logic                               ready;
  logic                               activity;
  logic [idpc_pkg::TicksWidth-1:0]    ticks_advanced;

  modport source (output valid, output activity, output ticks_advanced, input ready);
  modport sink   (input valid, input activity, input ticks_advanced, output ready);
endinterface

// ----- rtl/idpc_cmd_if.sv -----
interface idpc_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [idpc_pkg::ByteWidth-1:0]   command_byte;
  logic [1:0]                       new_level;
  logic                             last_byte;

  modport source (output valid, output command_byte, output new_level, output last_byte,
                  input ready);
  modport sink   (input valid, input command_byte, input new_level, input last_byte,
                  output ready);
endinterface

// ----- rtl/idpc_front.sv -----
module idpc_front #(
  parameter int unsigned IdleCountWidth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic                                 activity_i,
  input  logic [idpc_pkg::TicksWidth-1:0]      ticks_advanced_i,
  input  logic [idpc_pkg::TimeoutWidth-1:0]    dim_timeout_i,
  input  logic [idpc_pkg::TimeoutWidth-1:0]    off_timeout_i,
  input  logic                                 q_full_i,
  output idpc_pkg::push_t                      push_o
);

  localparam int unsigned AddW = (IdleCountWidth > idpc_pkg::TicksWidth) ?
                                 IdleCountWidth : idpc_pkg::TicksWidth;
  localparam int unsigned SumW = AddW + 1;
  localparam int unsigned CmpW = (IdleCountWidth > idpc_pkg::TimeoutWidth) ?
                                 IdleCountWidth : idpc_pkg::TimeoutWidth;

  logic [IdleCountWidth-1:0] idle_q, idle_d;
  idpc_pkg::level_e          level_q, target;
  logic [SumW-1:0]           sum, sat_max;
  logic [CmpW-1:0]           idle_cmp, dim_cmp, off_cmp;
  logic                      accept;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;

  assign sum     = SumW'(idle_q) + SumW'(ticks_advanced_i);
  assign sat_max = {{(SumW-IdleCountWidth){1'b0}}, {IdleCountWidth{1'b1}}};

  always_comb begin
    if (activity_i) begin
      idle_d = '0;
    end else if (sum > sat_max) begin
      idle_d = {IdleCountWidth{1'b1}};
    end else begin
      idle_d = sum[IdleCountWidth-1:0];
    end
  end

  assign idle_cmp = CmpW'(idle_d);
  assign dim_cmp  = CmpW'(dim_timeout_i);
  assign off_cmp  = CmpW'(off_timeout_i);

  // off takes priority over dim
  always_comb begin
    if (idle_cmp >= off_cmp) begin
      target = idpc_pkg::LVL_OFF;
    end else if (idle_cmp >= dim_cmp) begin
      target = idpc_pkg::LVL_DIM;
    end else begin
      target = idpc_pkg::LVL_BRIGHT;
    end
  end

  assign push_o.push  = accept && (target != level_q);
  assign push_o.level = target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q  <= '0;
      level_q <= idpc_pkg::LVL_BRIGHT;
    end else if (accept) begin
      idle_q  <= idle_d;
      level_q <= target;
    end
  end

endmodule

// ----- rtl/idpc_queue.sv -----
module idpc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  idpc_pkg::push_t   push_i,
  input  logic              pop_i,
  output idpc_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = (idpc_pkg::QueueDepth > 1) ? $clog2(idpc_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(idpc_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(idpc_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(idpc_pkg::QueueDepth);

  idpc_pkg::level_e mem_q [idpc_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.level = mem_q[rd_q];

  assign do_push = push_i.push && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/idpc_back.sv -----
module idpc_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  idpc_pkg::cfg_t                   cfg_i,
  input  idpc_pkg::q_stat_t                q_stat_i,
  output logic                             pop_o,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [idpc_pkg::ByteWidth-1:0]   command_byte_o,
  output logic [1:0]                       new_level_o,
  output logic                             last_byte_o
);

  logic                              busy_q;
  idpc_pkg::level_e                  lvl_q;
  logic [idpc_pkg::StepWidth-1:0]    step_q;
  logic                              out_valid_q;
  logic [idpc_pkg::ByteWidth-1:0]    out_byte_q;
  idpc_pkg::level_e                  out_lvl_q;
  logic                              out_last_q;
  logic                              out_free, emit, is_last;

  assign out_free = !out_valid_q || ready_i;
  assign pop_o    = !busy_q && !q_stat_i.empty;
  assign emit     = busy_q && out_free;
  assign is_last  = (lvl_q == idpc_pkg::LVL_OFF) || (step_q == idpc_pkg::STEP_CON_VAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        step_q <= idpc_pkg::STEP_ON;
      end else if (emit) begin
        step_q <= step_q + 1'b1;
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      lvl_q <= q_stat_i.level;
    end
    if (emit) begin
      out_byte_q <= idpc_pkg::cmd_byte(lvl_q, step_q, cfg_i);
      out_lvl_q  <= lvl_q;
      out_last_q <= is_last;
    end
  end

  assign valid_o        = out_valid_q;
  assign command_byte_o = out_byte_q;
  assign new_level_o    = out_lvl_q;
  assign last_byte_o    = out_last_q;

endmodule

// ----- rtl/idle_dimming_display_power_controller_top.sv -----
// Channel   Dir   Handshake      Word
// scan_i    in    valid/ready    activity, ticks_advanced
// cmd_o     out   valid/ready    command_byte, new_level, last_byte
// cfg       in    cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// When a scan is taken, the idle count and level update at once.
// For a level change the byte sequencer first loads the change from the queue, then
// emits its bytes one by one: seven for a power-up run, one for power-off.
// Scans are refused only while the two-entry change queue is full.
// Reset (rst_ni low, asynchronous) returns the level to bright and the count to zero.
module idle_dimming_display_power_controller_top #(
  parameter int unsigned IDLE_COUNT_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  idpc_scan_if.sink                            scan_i,
  idpc_cmd_if.source                           cmd_o,
  input  logic                                 cfg_we_i,
  input  logic [idpc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [idpc_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  idpc_pkg::cfg_t    cfg_q;
  idpc_pkg::push_t   push;
  idpc_pkg::q_stat_t q_stat;
  logic              pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_timeout      <= idpc_pkg::DIM_TIMEOUT_RST;
      cfg_q.off_timeout      <= idpc_pkg::OFF_TIMEOUT_RST;
      cfg_q.bright_vcomh     <= idpc_pkg::BRIGHT_VCOMH_RST;
      cfg_q.bright_precharge <= idpc_pkg::BRIGHT_PRECHARGE_RST;
      cfg_q.bright_contrast  <= idpc_pkg::BRIGHT_CONTRAST_RST;
      cfg_q.dim_vcomh        <= idpc_pkg::DIM_VCOMH_RST;
      cfg_q.dim_precharge    <= idpc_pkg::DIM_PRECHARGE_RST;
      cfg_q.dim_contrast     <= idpc_pkg::DIM_CONTRAST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        idpc_pkg::REG_DIM_TIMEOUT:      cfg_q.dim_timeout      <= cfg_data_i;
        idpc_pkg::REG_OFF_TIMEOUT:      cfg_q.off_timeout      <= cfg_data_i;
        idpc_pkg::REG_BRIGHT_VCOMH:     cfg_q.bright_vcomh     <= cfg_data_i[7:0];
        idpc_pkg::REG_BRIGHT_PRECHARGE: cfg_q.bright_precharge <= cfg_data_i[7:0];
        idpc_pkg::REG_BRIGHT_CONTRAST:  cfg_q.bright_contrast  <= cfg_data_i[7:0];
        idpc_pkg::REG_DIM_VCOMH:        cfg_q.dim_vcomh        <= cfg_data_i[7:0];
        idpc_pkg::REG_DIM_PRECHARGE:    cfg_q.dim_precharge    <= cfg_data_i[7:0];
        idpc_pkg::REG_DIM_CONTRAST:     cfg_q.dim_contrast     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  idpc_front #(
    .IdleCountWidth (IDLE_COUNT_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (scan_i.valid),
    .ready_o          (scan_i.ready),
    .activity_i       (scan_i.activity),
    .ticks_advanced_i (scan_i.ticks_advanced),
    .dim_timeout_i    (cfg_q.dim_timeout),
    .off_timeout_i    (cfg_q.off_timeout),
    .q_full_i         (q_stat.full),
    .push_o           (push)
  );

  idpc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (q_stat)
  );

  idpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .valid_o        (cmd_o.valid),
    .ready_i        (cmd_o.ready),
    .command_byte_o (cmd_o.command_byte),
    .new_level_o    (cmd_o.new_level),
    .last_byte_o    (cmd_o.last_byte)
  );

endmodule

// ----- rtl/idpc_checker.sv -----
module idpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [idpc_pkg::ByteWidth-1:0] command_byte_i,
  input logic [1:0]                     new_level_i,
  input logic                           last_byte_i
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(command_byte_i) &&
    $stable(new_level_i))
    else $error("stalled command word changed");

  a_level_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (new_level_i == idpc_pkg::LVL_OFF || new_level_i == idpc_pkg::LVL_DIM ||
                     new_level_i == idpc_pkg::LVL_BRIGHT))
    else $error("unused level code on output");

  a_off_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && new_level_i == idpc_pkg::LVL_OFF |->
    last_byte_i && command_byte_i == idpc_pkg::CMD_DISPLAY_OFF)
    else $error("power-off run is not a single display-off byte");

  // a run stays on one level until its last byte
  a_run_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_byte_i |=>
    !out_valid_i || new_level_i == $past(new_level_i))
    else $error("level changed inside a command run");

endmodule

bind idle_dimming_display_power_controller_top idpc_checker u_idpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (cmd_o.valid),
  .out_ready_i    (cmd_o.ready),
  .command_byte_i (cmd_o.command_byte),
  .new_level_i    (cmd_o.new_level),
  .last_byte_i    (cmd_o.last_byte)
);

// ----- tb/tb_idle_dimming_display_power_controller_top.sv -----
module tb_idle_dimming_display_power_controller_top;

  localparam int unsigned IdleWidth  = 16;
  localparam int unsigned QuietLimit = 4000;

  typedef struct packed {
    logic                            activity;
    logic [idpc_pkg::TicksWidth-1:0] ticks;
  } scan_t;

  typedef struct packed {
    logic [idpc_pkg::ByteWidth-1:0] code;
    idpc_pkg::level_e               level;
    logic                           last;
  } cmd_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              scan_valid = 1'b0;
  logic                              scan_act   = 1'b0;
  logic [idpc_pkg::TicksWidth-1:0]   scan_ticks = '0;
  logic                              cmd_ready  = 1'b0;
  logic                              cfg_we     = 1'b0;
  logic [idpc_pkg::CfgIdxWidth-1:0]  cfg_idx    = '0;
  logic [idpc_pkg::CfgDataWidth-1:0] cfg_data   = '0;

  idpc_scan_if scan_if ();
  idpc_cmd_if  cmd_if ();

  assign scan_if.valid          = scan_valid;
  assign scan_if.activity       = scan_act;
  assign scan_if.ticks_advanced = scan_ticks;
  assign cmd_if.ready           = cmd_ready;

  idle_dimming_display_power_controller_top #(
    .IDLE_COUNT_WIDTH(IdleWidth)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .scan_i    (scan_if),
    .cmd_o     (cmd_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // shadow of the block's registers and state
  idpc_pkg::cfg_t reg_shadow = '{dim_timeout: idpc_pkg::DIM_TIMEOUT_RST,
                                 off_timeout: idpc_pkg::OFF_TIMEOUT_RST,
                                 bright_vcomh: idpc_pkg::BRIGHT_VCOMH_RST,
                                 bright_precharge: idpc_pkg::BRIGHT_PRECHARGE_RST,
                                 bright_contrast: idpc_pkg::BRIGHT_CONTRAST_RST,
                                 dim_vcomh: idpc_pkg::DIM_VCOMH_RST,
                                 dim_precharge: idpc_pkg::DIM_PRECHARGE_RST,
                                 dim_contrast: idpc_pkg::DIM_CONTRAST_RST};
  logic [IdleWidth-1:0] idle_count  = '0;
  idpc_pkg::level_e     shown_level = idpc_pkg::LVL_BRIGHT;

  scan_t     scans_pending[$];
  cmd_word_t cmd_bytes_due[$];
  int        errors = 0;
  int        scans_made = 0;

  int   burst_left = 1;
  int   gap_left = 0;
  logic hold_for_drain = 1'b0;
  logic [8:0] ready_tick = '0;
  int   quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_word(logic [idpc_pkg::ByteWidth-1:0] code,
                                    idpc_pkg::level_e lvl, logic last);
    cmd_word_t w;
    w.code  = code;
    w.level = lvl;
    w.last  = last;
    cmd_bytes_due.push_back(w);
  endfunction

  function automatic void predict_level_change(logic act,
                                               logic [idpc_pkg::TicksWidth-1:0] ticks);
    logic [IdleWidth:0]             sum;
    idpc_pkg::level_e               target;
    logic [idpc_pkg::ByteWidth-1:0] vcomh;
    logic [idpc_pkg::ByteWidth-1:0] pre;
    logic [idpc_pkg::ByteWidth-1:0] con;
    if (act) begin
      idle_count = '0;
    end else begin
      sum = {1'b0, idle_count} + ticks;
      idle_count = sum[IdleWidth] ? '1 : sum[IdleWidth-1:0];
    end
    // off is tested before dim
    if (idle_count >= reg_shadow.off_timeout) begin
      target = idpc_pkg::LVL_OFF;
    end else if (idle_count >= reg_shadow.dim_timeout) begin
      target = idpc_pkg::LVL_DIM;
    end else begin
      target = idpc_pkg::LVL_BRIGHT;
    end
    if (target == shown_level) return;
    shown_level = target;
    if (target == idpc_pkg::LVL_OFF) begin
      push_word(idpc_pkg::CMD_DISPLAY_OFF, target, 1'b1);
    end else begin
      vcomh = (target == idpc_pkg::LVL_DIM) ? reg_shadow.dim_vcomh : reg_shadow.bright_vcomh;
      pre   = (target == idpc_pkg::LVL_DIM) ? reg_shadow.dim_precharge :
                                              reg_shadow.bright_precharge;
      con   = (target == idpc_pkg::LVL_DIM) ? reg_shadow.dim_contrast :
                                              reg_shadow.bright_contrast;
      push_word(idpc_pkg::CMD_DISPLAY_ON, target, 1'b0);
      push_word(idpc_pkg::CMD_SET_VCOMH, target, 1'b0);
      push_word(vcomh, target, 1'b0);
      push_word(idpc_pkg::CMD_SET_PRECHARGE, target, 1'b0);
      push_word(pre, target, 1'b0);
      push_word(idpc_pkg::CMD_SET_CONTRAST, target, 1'b0);
      push_word(con, target, 1'b1);
    end
  endfunction

  function automatic logic [idpc_pkg::TicksWidth-1:0] pick_ticks();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return idpc_pkg::TicksWidth'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic add_scan(logic act, logic [idpc_pkg::TicksWidth-1:0] ticks);
    scan_t s;
    s.activity = act;
    s.ticks    = ticks;
    scans_pending.push_back(s);
    scans_made++;
  endtask

  task automatic write_reg(logic [idpc_pkg::CfgIdxWidth-1:0] idx,
                           logic [idpc_pkg::CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      idpc_pkg::REG_DIM_TIMEOUT:      reg_shadow.dim_timeout      = data;
      idpc_pkg::REG_OFF_TIMEOUT:      reg_shadow.off_timeout      = data;
      idpc_pkg::REG_BRIGHT_VCOMH:     reg_shadow.bright_vcomh     = data[idpc_pkg::ByteWidth-1:0];
      idpc_pkg::REG_BRIGHT_PRECHARGE:
        reg_shadow.bright_precharge = data[idpc_pkg::ByteWidth-1:0];
      idpc_pkg::REG_BRIGHT_CONTRAST:
        reg_shadow.bright_contrast = data[idpc_pkg::ByteWidth-1:0];
      idpc_pkg::REG_DIM_VCOMH:        reg_shadow.dim_vcomh        = data[idpc_pkg::ByteWidth-1:0];
      idpc_pkg::REG_DIM_PRECHARGE:    reg_shadow.dim_precharge    = data[idpc_pkg::ByteWidth-1:0];
      idpc_pkg::REG_DIM_CONTRAST:     reg_shadow.dim_contrast     = data[idpc_pkg::ByteWidth-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait until every scan is taken and every byte has come out, then let the sequencer settle
  task automatic drain();
    while (scans_pending.size() != 0 || scan_valid || cmd_bytes_due.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // scan driver: bursts with random gaps, now and then a pause until all bytes are out
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      scan_valid <= 1'b0;
    end else begin
      if (scan_valid && scan_if.ready) begin
        predict_level_change(scan_act, scan_ticks);
        void'(scans_pending.pop_front());
      end
      if (hold_for_drain && cmd_bytes_due.size() == 0) hold_for_drain = 1'b0;
      if (!scan_valid || scan_if.ready) begin
        if (gap_left != 0 || hold_for_drain || scans_pending.size() == 0) begin
          scan_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          scan_valid <= 1'b1;
          scan_act   <= scans_pending[0].activity;
          scan_ticks <= scans_pending[0].ticks;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left     = $urandom_range(1, 12);
            gap_left       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            hold_for_drain = ($urandom_range(0, 9) == 0);
          end
        end
      end
    end
  end

  // command monitor; ready follows a pattern that changes with ready_tick[8:7]
  always @(posedge clk_i) begin
    cmd_word_t w;
    if (!rst_ni) begin
      cmd_ready <= 1'b0;
    end else begin
      ready_tick <= ready_tick + 1'b1;
      if (cmd_if.valid && cmd_ready) begin
        if (cmd_bytes_due.size() == 0) begin
          $error("unexpected command word %0h", cmd_if.command_byte);
          errors++;
        end else begin
          w = cmd_bytes_due.pop_front();
          if (cmd_if.command_byte !== w.code) begin
            $error("command_byte: expected %0h, got %0h", w.code, cmd_if.command_byte);
            errors++;
          end
          if (cmd_if.new_level !== w.level) begin
            $error("new_level: expected %0d, got %0d", w.level, cmd_if.new_level);
            errors++;
          end
          if (cmd_if.last_byte !== w.last) begin
            $error("last_byte: expected %0b, got %0b", w.last, cmd_if.last_byte);
            errors++;
          end
        end
      end
      case (ready_tick[8:7])
        2'd0:    cmd_ready <= 1'b1;
        2'd1:    cmd_ready <= 1'($urandom_range(0, 1));
        2'd2:    cmd_ready <= (ready_tick[2:0] == 3'd0);
        default: cmd_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((scan_valid && scan_if.ready) || (cmd_if.valid && cmd_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb_idle_dimming_display_power_controller_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_no;
    int style;
    int budget;
    int made;
    int run_len;
    int r;
    int dim_t;
    int off_t;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: dim on the third full scan, off on the seventh, activity wakes
    repeat (3) add_scan(1'b0, '1);
    add_scan(1'b0, '0);
    repeat (4) add_scan(1'b0, '1);
    add_scan(1'b1, '1);
    add_scan(1'b1, '0);
    drain();

    // dim timeout zero dims right after activity; upper data bits of byte registers drop
    write_reg(idpc_pkg::REG_DIM_TIMEOUT, 16'd0);
    write_reg(idpc_pkg::REG_OFF_TIMEOUT, 16'hFFFF);
    write_reg(idpc_pkg::REG_BRIGHT_VCOMH, 16'h12FF);
    write_reg(idpc_pkg::REG_BRIGHT_PRECHARGE, 16'hFF00);
    write_reg(idpc_pkg::REG_BRIGHT_CONTRAST, 16'h5A5A);
    write_reg(idpc_pkg::REG_DIM_VCOMH, 16'hFFFF);
    write_reg(idpc_pkg::REG_DIM_PRECHARGE, 16'h0000);
    write_reg(idpc_pkg::REG_DIM_CONTRAST, 16'hA5C3);
    add_scan(1'b1, 10'd0);
    add_scan(1'b0, '1);
    add_scan(1'b1, 10'd512);
    drain();

    // off timeout zero: off on every scan, activity too
    write_reg(idpc_pkg::REG_OFF_TIMEOUT, 16'd0);
    add_scan(1'b0, 10'd17);
    add_scan(1'b1, 10'd0);
    drain();

    // off timeout below dim timeout
    write_reg(idpc_pkg::REG_DIM_TIMEOUT, 16'd600);
    write_reg(idpc_pkg::REG_OFF_TIMEOUT, 16'd300);
    add_scan(1'b1, 10'd0);
    add_scan(1'b0, 10'd400);
    add_scan(1'b1, 10'd0);
    add_scan(1'b0, 10'd299);
    add_scan(1'b0, 10'd1);
    drain();

    scans_made = 0;
    phase_no   = 0;
    while (scans_made < 320) begin
      style = phase_no % 5;
      case (style)
        0: begin
          // near the top of the count so that it saturates
          dim_t = $urandom_range(40000, 65535);
          off_t = $urandom_range(0, 1) ? 65535 : 65534;
        end
        1: begin
          dim_t = $urandom_range(100, 3000);
          off_t = dim_t + $urandom_range(0, 4000);
        end
        2: begin
          off_t = $urandom_range(0, 2000);
          dim_t = off_t + $urandom_range(1, 3000);
        end
        3: begin
          off_t = 0;
          dim_t = $urandom_range(0, 65535);
        end
        default: begin
          dim_t = 0;
          off_t = $urandom_range(1, 5000);
        end
      endcase
      write_reg(idpc_pkg::REG_DIM_TIMEOUT, dim_t[idpc_pkg::CfgDataWidth-1:0]);
      write_reg(idpc_pkg::REG_OFF_TIMEOUT, off_t[idpc_pkg::CfgDataWidth-1:0]);
      for (r = idpc_pkg::REG_BRIGHT_VCOMH; r <= idpc_pkg::REG_DIM_CONTRAST; r++)
        if ($urandom_range(0, 1))
          write_reg(r[idpc_pkg::CfgIdxWidth-1:0],
                    idpc_pkg::CfgDataWidth'($urandom_range(0, 65535)));

      budget = (style == 0) ? 80 : 30;
      made   = 0;
      while (made < budget && scans_made < 320) begin
        run_len = (style == 0) ? $urandom_range(75, 90) : $urandom_range(1, 15);
        // stop at the item budget
        if (scans_made + run_len >= 320) run_len = 319 - scans_made;
        repeat (run_len) begin
          if (style == 0) add_scan(1'b0, idpc_pkg::TicksWidth'($urandom_range(900, 1023)));
          else if ($urandom_range(0, 19) == 0) add_scan(1'b1, pick_ticks());
          else add_scan(1'b0, pick_ticks());
          made++;
        end
        add_scan(1'b1, pick_ticks());
        made++;
      end
      drain();
      phase_no++;
    end

    drain();
    if (errors == 0 && cmd_bytes_due.size() == 0) begin
      $display("tb_idle_dimming_display_power_controller_top OK");
    end else begin
      $display("tb_idle_dimming_display_power_controller_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- idle_dimming_display_power_controller_top.f -----
rtl/idpc_pkg.sv
rtl/idpc_scan_if.sv
rtl/idpc_cmd_if.sv
rtl/idpc_front.sv
rtl/idpc_queue.sv
rtl/idpc_back.sv
rtl/idle_dimming_display_power_controller_top.sv
rtl/idpc_checker.sv
tb/tb_idle_dimming_display_power_controller_top.sv
